// File: hw/rtl/itts_pkg.sv
// Shared types, character class codes and the operator name table of the token scanner.
package itts_pkg;

    typedef struct packed {
        logic [20:0] code_point;
        logic        scan_start;
        logic        times_allowed;
        logic        end_of_input;
    } chr_item_t;

    typedef struct packed {
        logic        token_found;
        logic [15:0] token_length;
    } tok_item_t;

    typedef logic [2:0] cls_t;

    localparam cls_t CLS_NONE   = 3'd0;
    localparam cls_t CLS_WS     = 3'd1;
    localparam cls_t CLS_NL     = 3'd2;
    localparam cls_t CLS_LETTER = 3'd3;
    localparam cls_t CLS_DIGIT  = 3'd4;
    localparam cls_t CLS_BSLASH = 3'd5;
    localparam cls_t CLS_LBRACK = 3'd6;
    localparam cls_t CLS_RBRACK = 3'd7;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] ch;
        logic       scan_start;
        logic       times_allowed;
    } scan_entry_t;

    localparam int QUEUE_DEPTH = 2;

    localparam int KNOWN_NAMES = 37;

    // Names are held right-aligned in 16 bytes, first letter in the highest used byte.
    localparam logic [127:0] OP_NAMES [KNOWN_NAMES] = '{
        "Plus", "Minus", "PlusMinus", "MinusPlus", "Square", "Del",
        "DifferentialD", "Not", "Sqrt", "Cross", "SmallCircle", "Backslash",
        "Diamond", "Wedge", "Vee", "CircleTimes", "CircleDot", "Star",
        "VerticalTilde", "Coproduct", "Cap", "Cup", "CirclePlus", "CircleMinus",
        "Rule", "RuleDelayed", "TwoWayRule", "Therefore", "RightTee",
        "DoubleRightTee", "SuchThat", "LeftTee", "DoubleLeftTee", "UpTee",
        "DownTee", "Because", "Application"
    };

    localparam logic [3:0] OP_LEN [KNOWN_NAMES] = '{
        4'd4,  4'd5,  4'd9,  4'd9,  4'd6,  4'd3,
        4'd13, 4'd3,  4'd4,  4'd5,  4'd11, 4'd9,
        4'd7,  4'd5,  4'd3,  4'd11, 4'd9,  4'd4,
        4'd13, 4'd9,  4'd3,  4'd3,  4'd10, 4'd11,
        4'd4,  4'd11, 4'd10, 4'd9,  4'd8,
        4'd14, 4'd8,  4'd7,  4'd13, 4'd5,
        4'd7,  4'd7,  4'd11
    };

    // Letter at position pos of name idx, or zero past the end of the name.
    function automatic logic [7:0] op_char(input logic [5:0] idx, input logic [4:0] pos);
        logic [127:0] word;
        logic [3:0]   off;
        begin
            if (pos >= 5'(OP_LEN[idx])) begin
                return 8'd0;
            end
            off  = 4'(5'(OP_LEN[idx]) - 5'd1 - pos);
            word = OP_NAMES[idx] >> {off, 3'b000};
            return word[7:0];
        end
    endfunction

endpackage

// File: hw/rtl/implicit_times_token_scanner_top.sv
// Top level of the implicit multiplication token scanner.
// The scanner takes one character per clock cycle, sustained, while the result side keeps taking
// results. A result held by a stalled receiver halts the back end, so the queue fills and the
// input stalls until that result is taken. A classified character enters a two-entry queue when
// it is accepted and is processed by the scan state machine once it heads the queue and the
// result register is free; the character that decides a result also loads the result register.
// The rate is set by the back end, which updates the scan state and the operator name match
// mask for each character that it takes.
// The block needs no start-up sweep and accepts characters from the first cycle after reset.
module implicit_times_token_scanner_top
    import itts_pkg::*;
#(
    parameter int NAME_LIMIT    = 29,
    parameter int TABLE_ENTRIES = 37,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chr_valid,
    output logic      chr_stall,
    input  chr_item_t chr_item,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok_item
);

    logic        push;
    scan_entry_t push_entry;
    logic        queue_full;
    logic        head_valid;
    scan_entry_t head;
    logic        pop;

    itts_front u_front (
        .chr_valid  (chr_valid),
        .chr_stall  (chr_stall),
        .chr_item   (chr_item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    itts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    itts_back #(
        .NAME_LIMIT    (NAME_LIMIT),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_item   (tok_item)
    );

endmodule

// File: hw/rtl/itts_front.sv
// Front end: accepts characters and sorts each into a character class for the scanner.
module itts_front
    import itts_pkg::*;
(
    input  logic        chr_valid,
    output logic        chr_stall,
    input  chr_item_t   chr_item,
    input  logic        queue_full,
    output logic        push,
    output scan_entry_t push_entry
);

    function automatic cls_t classify(input logic [20:0] cp, input logic eof);
        cls_t c;
        begin
            case (cp) inside
                21'h000020, 21'h000009, 21'h0000A0, 21'h001680, 21'h00180E,
                [21'h002000:21'h00200B], 21'h00202F, 21'h00205F, 21'h003000,
                21'h00FEFF:
                    c = CLS_WS;
                21'h00000A, 21'h00000B, 21'h00000C, 21'h00000D,
                21'h002028, 21'h002029:
                    c = CLS_NL;
                [21'h000041:21'h00005A], [21'h000061:21'h00007A]:
                    c = CLS_LETTER;
                [21'h000030:21'h000039]:
                    c = CLS_DIGIT;
                21'h00005C:
                    c = CLS_BSLASH;
                21'h00005B:
                    c = CLS_LBRACK;
                21'h00005D:
                    c = CLS_RBRACK;
                default:
                    c = CLS_NONE;
            endcase
            // The end of input behaves as a character that belongs to no class.
            if (eof) begin
                c = CLS_NONE;
            end
            return c;
        end
    endfunction

    assign chr_stall = queue_full;
    assign push      = chr_valid && !queue_full;

    always_comb
    begin
        push_entry.cls           = classify(chr_item.code_point, chr_item.end_of_input);
        push_entry.ch            = chr_item.code_point[7:0];
        push_entry.scan_start    = chr_item.scan_start;
        push_entry.times_allowed = chr_item.times_allowed;
    end

endmodule

// File: hw/rtl/itts_queue.sv
// Short queue of classified characters between the front end and the scanner.
module itts_queue
    import itts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  scan_entry_t push_entry,
    output logic        queue_full,
    output logic        head_valid,
    output scan_entry_t head,
    input  logic        pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scan_entry_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/itts_back.sv
// Back end: the scan state machine, the operator name match mask and the result register.
module itts_back
    import itts_pkg::*;
#(
    parameter int NAME_LIMIT    = 29,
    parameter int TABLE_ENTRIES = 37,
    parameter int LENGTH_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  scan_entry_t head,
    output logic        pop,
    output logic        tok_valid,
    input  logic        tok_stall,
    output tok_item_t   tok_item
);

    localparam logic [2:0] PH_DONE = 3'd0;
    localparam logic [2:0] PH_LEAD = 3'd1;
    localparam logic [2:0] PH_BSWS = 3'd3;
    localparam logic [2:0] PH_CONT = 3'd4;
    localparam logic [2:0] PH_NAME = 3'd5;

    localparam int NLEN_W       = $clog2(NAME_LIMIT + 1);
    localparam int ACCEPT_FIRST = 4;
    localparam int ACCEPT_LAST  = 8;

    logic [2:0]             phase_reg, phase_next;
    logic                   saw_ws_reg, saw_ws_next;
    logic                   allowed_reg, allowed_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [LENGTH_BITS-1:0] end_mark_reg, end_mark_next;
    logic [KNOWN_NAMES-1:0] mask_reg, mask_next;
    logic [NLEN_W-1:0]      nlen_reg, nlen_next;
    logic                   tok_valid_reg, tok_valid_next;
    tok_item_t              tok_item_reg;

    logic [2:0]             eff_phase;
    logic                   eff_saw_ws;
    logic                   eff_allowed;
    logic [LENGTH_BITS-1:0] eff_count;
    logic [LENGTH_BITS-1:0] eff_end_mark;
    logic [KNOWN_NAMES-1:0] eff_mask;
    logic [NLEN_W-1:0]      eff_nlen;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [KNOWN_NAMES-1:0] letter_keep;
    logic [KNOWN_NAMES-1:0] full_match;
    logic [KNOWN_NAMES-1:0] reject_sel;
    logic                   word_ok;
    logic                   emit;
    logic                   found;

    assign pop       = head_valid && (!tok_valid_reg || !tok_stall);
    assign tok_valid = tok_valid_reg;
    assign tok_item  = tok_item_reg;

    // A start mark abandons whatever attempt is running and begins afresh.
    always_comb
    begin
        if (head.scan_start) begin
            eff_phase    = PH_LEAD;
            eff_saw_ws   = 1'b0;
            eff_allowed  = head.times_allowed;
            eff_count    = '0;
            eff_end_mark = '0;
            eff_mask     = '1;
            eff_nlen     = '0;
        end else begin
            eff_phase    = phase_reg;
            eff_saw_ws   = saw_ws_reg;
            eff_allowed  = allowed_reg;
            eff_count    = count_reg;
            eff_end_mark = end_mark_reg;
            eff_mask     = mask_reg;
            eff_nlen     = nlen_reg;
        end
    end

    assign count_inc = (eff_count == '1) ? eff_count : eff_count + LENGTH_BITS'(1);

    always_comb
    begin
        for (int i = 0; i < KNOWN_NAMES; i++) begin
            letter_keep[i] = (op_char(6'(i), 5'(eff_nlen)) == head.ch);
            full_match[i]  = eff_mask[i] && (5'(eff_nlen) == 5'(OP_LEN[i]));
            reject_sel[i]  = (i < TABLE_ENTRIES) && !(i >= ACCEPT_FIRST && i <= ACCEPT_LAST);
        end
    end

    // Names are distinct, so at most one entry can match in full.
    assign word_ok = !(|(full_match & reject_sel));

    always_comb
    begin
        phase_next    = eff_phase;
        saw_ws_next   = eff_saw_ws;
        allowed_next  = eff_allowed;
        count_next    = eff_count;
        end_mark_next = eff_end_mark;
        mask_next     = eff_mask;
        nlen_next     = eff_nlen;
        emit          = 1'b0;
        found         = 1'b0;
        unique case (eff_phase)
            PH_LEAD:
            begin
                if (head.cls == CLS_WS) begin
                    saw_ws_next = 1'b1;
                    count_next  = count_inc;
                end else begin
                    end_mark_next = eff_count;
                    if (!(eff_allowed && eff_saw_ws)) begin
                        emit = 1'b1;
                    end else if (head.cls == CLS_LETTER || head.cls == CLS_DIGIT) begin
                        emit  = 1'b1;
                        found = 1'b1;
                    end else if (head.cls == CLS_BSLASH) begin
                        count_next = count_inc;
                        phase_next = PH_BSWS;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            PH_BSWS:
            begin
                if (head.cls == CLS_WS) begin
                    count_next = count_inc;
                end else if (head.cls == CLS_NL) begin
                    count_next = count_inc;
                    phase_next = PH_CONT;
                end else if (head.cls == CLS_LBRACK) begin
                    count_next = count_inc;
                    mask_next  = '1;
                    nlen_next  = '0;
                    phase_next = PH_NAME;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_CONT:
            begin
                if (head.cls == CLS_WS) begin
                    count_next = count_inc;
                end else begin
                    // The continuation is absorbed: the token end moves past it.
                    end_mark_next = eff_count;
                    if (head.cls == CLS_LETTER || head.cls == CLS_DIGIT) begin
                        emit  = 1'b1;
                        found = 1'b1;
                    end else if (head.cls == CLS_BSLASH) begin
                        count_next = count_inc;
                        phase_next = PH_BSWS;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            PH_NAME:
            begin
                if (head.cls == CLS_LETTER) begin
                    if (eff_nlen >= NLEN_W'(NAME_LIMIT)) begin
                        emit = 1'b1;
                    end else begin
                        mask_next  = eff_mask & letter_keep;
                        nlen_next  = eff_nlen + NLEN_W'(1);
                        count_next = count_inc;
                    end
                end else if (head.cls == CLS_RBRACK) begin
                    emit  = 1'b1;
                    found = word_ok;
                end else begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
        if (emit) begin
            phase_next = PH_DONE;
        end
    end

    always_comb
    begin
        if (pop && emit) begin
            tok_valid_next = 1'b1;
        end else if (tok_stall) begin
            tok_valid_next = tok_valid_reg;
        end else begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_DONE;
            saw_ws_reg    <= 1'b0;
            allowed_reg   <= 1'b0;
            count_reg     <= '0;
            end_mark_reg  <= '0;
            mask_reg      <= '1;
            nlen_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg    <= phase_next;
                saw_ws_reg   <= saw_ws_next;
                allowed_reg  <= allowed_next;
                count_reg    <= count_next;
                end_mark_reg <= end_mark_next;
                mask_reg     <= mask_next;
                nlen_reg     <= nlen_next;
            end
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit) begin
            tok_item_reg.token_found  <= found;
            tok_item_reg.token_length <= 16'(end_mark_next);
        end
    end

    // The token end never runs ahead of the characters consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        end_mark_reg <= count_reg)
    else $error("token end mark is beyond the consumed count");

    // A decision always closes the attempt.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit) |=> (phase_reg == PH_DONE))
    else $error("scan attempt still active after a result");

    // A held result is never overwritten by a new transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_reg && tok_stall) |-> !pop)
    else $error("character taken while a result is stalled");

    // A token is only reported where whitespace was skipped and the token was allowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit && found) |-> (eff_allowed && eff_saw_ws))
    else $error("token reported without leading whitespace or permission");

endmodule
